FILE: rtl/srs_pkg.sv
// Shared types, constants and a helper function for the slot range stego step.
`default_nettype none
package srs_pkg;

    localparam int FIELD_W  = 31;   // message, mask and slot value width
    localparam int IDX_W    = 8;    // entry and token index width
    localparam int BETA_W   = 5;    // symbol_bits register width
    localparam int COUNT_W  = 9;    // active_slots register width
    localparam int MODE_W   = 2;

    localparam int DEF_MAX_ENTRIES = 256;
    localparam int DEF_MAX_BETA    = 31;

    localparam logic [BETA_W-1:0]  RST_SYMBOL_BITS  = 5'd8;
    localparam logic [COUNT_W-1:0] RST_ACTIVE_SLOTS = 9'd256;

    localparam logic [FIELD_W-1:0] ALL_ONES = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_ENCODE = 2'd1,
        MODE_DECODE = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic {
        REG_SYMBOL_BITS  = 1'b0,
        REG_ACTIVE_SLOTS = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_WALK   = 4'b0010,
        ST_PREFIX = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    // status of the table read port, in the cycle after the read
    typedef struct packed {
        logic vld;
        logic in_range;
    } rd_stat_t;

    // leading zero count of a 31-bit word with a sentinel one below it
    function automatic logic [BETA_W-1:0] lead_zeros(input logic [FIELD_W-1:0] x);
        logic [31:0]       v;
        logic [BETA_W-1:0] n;
        v = {x, 1'b1};
        n = '0;
        if (v[31:16] == 16'd0)
        begin
            n = n + 5'd16;
            v = v << 16;
        end
        if (v[31:24] == 8'd0)
        begin
            n = n + 5'd8;
            v = v << 8;
        end
        if (v[31:28] == 4'd0)
        begin
            n = n + 5'd4;
            v = v << 4;
        end
        if (v[31:30] == 2'd0)
        begin
            n = n + 5'd2;
            v = v << 2;
        end
        if (v[31] == 1'b0)
        begin
            n = n + 5'd1;
        end
        return n;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/srs_if.sv
// Input item and result item channel interfaces.
`default_nettype none
interface srs_in_if;
    logic                          valid;
    logic                          ready;
    logic [srs_pkg::MODE_W-1:0]    mode;
    logic [srs_pkg::IDX_W-1:0]     entry_index;
    logic [srs_pkg::FIELD_W-1:0]   range_start;
    logic [srs_pkg::FIELD_W-1:0]   range_end;
    logic [srs_pkg::FIELD_W-1:0]   msg_window;
    logic [srs_pkg::BETA_W-1:0]    valid_bits;
    logic [srs_pkg::FIELD_W-1:0]   mask_value;
    logic [srs_pkg::IDX_W-1:0]     token_index;

    modport source (output valid, mode, entry_index, range_start, range_end, msg_window,
                    valid_bits, mask_value, token_index, input ready);
    modport sink (input valid, mode, entry_index, range_start, range_end, msg_window,
                  valid_bits, mask_value, token_index, output ready);
endinterface

interface srs_out_if;
    logic                          valid;
    logic                          ready;
    logic [srs_pkg::IDX_W-1:0]     chosen_index;
    logic [srs_pkg::BETA_W-1:0]    prefix_len;
    logic [srs_pkg::FIELD_W-1:0]   prefix_bits;
    logic [srs_pkg::FIELD_W-1:0]   masked_value;
    logic                          was_decode;

    modport source (output valid, chosen_index, prefix_len, prefix_bits, masked_value,
                    was_decode, input ready);
    modport sink (input valid, chosen_index, prefix_len, prefix_bits, masked_value,
                  was_decode, output ready);
endinterface
`default_nettype wire

FILE: rtl/srs_table.sv
// Slot range table memory with registered read and range check of the read entry.
`default_nettype none
module srs_table #(
    parameter int DEPTH = srs_pkg::DEF_MAX_ENTRIES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire logic [AW-1:0]               wr_addr,
    input  wire logic [srs_pkg::FIELD_W-1:0] wr_start,
    input  wire logic [srs_pkg::FIELD_W-1:0] wr_end,
    input  wire logic                        rd_en,
    input  wire logic [AW-1:0]               rd_addr,
    input  wire logic [srs_pkg::FIELD_W-1:0] probe,
    output logic [srs_pkg::FIELD_W-1:0]      rd_start,
    output logic [srs_pkg::FIELD_W-1:0]      rd_end,
    output logic [AW-1:0]                    rd_idx,
    output srs_pkg::rd_stat_t                stat
);

    localparam int EW = 2 * srs_pkg::FIELD_W;

    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] rd_data_reg;
    logic          rd_vld_reg;
    logic [AW-1:0] rd_idx_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_start, wr_end};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= rd_en;
        end
    end

    assign rd_start = rd_data_reg[EW-1:srs_pkg::FIELD_W];
    assign rd_end   = rd_data_reg[srs_pkg::FIELD_W-1:0];
    assign rd_idx   = rd_idx_reg;

    always_comb
    begin
        stat.vld      = rd_vld_reg;
        stat.in_range = (probe >= rd_start) && (probe <= rd_end);
    end

endmodule
`default_nettype wire

FILE: rtl/slot_range_stego_step.sv
// Top level of the slot range stego step: control, configuration and result stage.
`default_nettype none
// One item at a time. A load writes one table entry when its entry_index is
// below MAX_ENTRIES. An encode reads the table one entry per cycle from entry 0
// until the first entry whose [start, end] holds message XOR mask, or the last
// active entry. A hit passes the table read register, the PREFIX state and the
// FINISH state to the output register, and the next item can be taken in the
// same cycle that the result appears on the output. The single read port of
// the table sets the pace of the walk. A decode reads one entry. A finished
// result waits in the output register while the next item is taken in. The
// table holds no reset value: decode or encode only over entries that were loaded.
module slot_range_stego_step #(
    parameter int MAX_ENTRIES = srs_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_BETA    = srs_pkg::DEF_MAX_BETA
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    srs_in_if.sink           item_in,
    srs_out_if.source        item_out
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int LW = (AW + 1 > srs_pkg::COUNT_W) ? AW + 1 : srs_pkg::COUNT_W;
    localparam int FW = srs_pkg::FIELD_W;
    localparam int BW = srs_pkg::BETA_W;

    // configuration
    logic [BW-1:0]               symbol_bits_reg;
    logic [srs_pkg::COUNT_W-1:0] active_slots_reg;
    logic                        cfg_wr;
    srs_pkg::reg_idx_t           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = srs_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_bits_reg  <= srs_pkg::RST_SYMBOL_BITS;
            active_slots_reg <= srs_pkg::RST_ACTIVE_SLOTS;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                srs_pkg::REG_SYMBOL_BITS:  symbol_bits_reg  <= pwdata[BW-1:0];
                srs_pkg::REG_ACTIVE_SLOTS: active_slots_reg <= pwdata[srs_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            srs_pkg::REG_SYMBOL_BITS:  prdata = 32'(symbol_bits_reg);
            srs_pkg::REG_ACTIVE_SLOTS: prdata = 32'(active_slots_reg);
            default:                   prdata = '0;
        endcase
    end

    // effective beta, count and input masking
    logic [BW-1:0] beta_eff;
    logic [LW-1:0] count_eff;
    logic [AW-1:0] last_idx;
    logic [AW-1:0] tok_idx;
    logic [FW-1:0] bmask;
    logic [FW-1:0] keep;
    logic [FW-1:0] msg_in;
    logic [FW-1:0] mask_in;
    logic          load_ok;

    always_comb
    begin
        if (symbol_bits_reg == '0)
        begin
            beta_eff = BW'(1);
        end
        else if (32'(symbol_bits_reg) > 32'(MAX_BETA))
        begin
            beta_eff = BW'(MAX_BETA);
        end
        else
        begin
            beta_eff = symbol_bits_reg;
        end

        if (active_slots_reg == '0)
        begin
            count_eff = LW'(1);
        end
        else if (LW'(active_slots_reg) > LW'(MAX_ENTRIES))
        begin
            count_eff = LW'(MAX_ENTRIES);
        end
        else
        begin
            count_eff = LW'(active_slots_reg);
        end
        last_idx = AW'(count_eff - LW'(1));
        tok_idx  = (LW'(item_in.token_index) < count_eff) ? AW'(item_in.token_index)
                                                           : last_idx;

        bmask = srs_pkg::ALL_ONES >> (BW'(FW) - beta_eff);
        keep  = bmask;
        if (item_in.valid_bits < beta_eff)
        begin
            keep = bmask & (srs_pkg::ALL_ONES << (beta_eff - item_in.valid_bits));
        end
        msg_in  = item_in.msg_window & keep;
        mask_in = item_in.mask_value & bmask;
        load_ok = LW'(item_in.entry_index) < LW'(MAX_ENTRIES);
    end

    // control
    srs_pkg::state_t state_reg;
    logic            dec_reg;
    logic [BW-1:0]   beta_reg;
    logic [FW-1:0]   bmask_reg;
    logic [FW-1:0]   msg_reg;
    logic [FW-1:0]   mask_reg;
    logic [FW-1:0]   r_reg;
    logic [AW-1:0]   walk_reg;
    logic [AW-1:0]   last_reg;
    logic            issued_reg;
    logic [AW-1:0]   hit_idx_reg;
    logic [FW-1:0]   start_reg;
    logic [FW-1:0]   end_reg;
    logic [BW-1:0]   cp_reg;
    logic [BW-1:0]   sh_reg;
    logic [FW-1:0]   src_reg;

    logic            acc;
    srs_pkg::mode_t  mode_in;
    logic            rd_en;
    logic            take;
    logic            out_free;

    logic [FW-1:0]   tb_start;
    logic [FW-1:0]   tb_end;
    logic [AW-1:0]   tb_idx;
    srs_pkg::rd_stat_t tb_stat;

    assign item_in.ready = (state_reg == srs_pkg::ST_IDLE);
    assign acc           = item_in.valid && item_in.ready;
    assign mode_in       = srs_pkg::mode_t'(item_in.mode);
    assign rd_en         = (state_reg == srs_pkg::ST_WALK) && !issued_reg;
    assign take          = (state_reg == srs_pkg::ST_WALK) && tb_stat.vld
                           && (dec_reg || tb_stat.in_range || tb_idx == last_reg);
    assign out_free      = !item_out.valid || item_out.ready;

    srs_table #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (acc && mode_in == srs_pkg::MODE_LOAD && load_ok),
        .wr_addr  (AW'(item_in.entry_index)),
        .wr_start (item_in.range_start),
        .wr_end   (item_in.range_end),
        .rd_en    (rd_en),
        .rd_addr  (walk_reg),
        .probe    (r_reg),
        .rd_start (tb_start),
        .rd_end   (tb_end),
        .rd_idx   (tb_idx),
        .stat     (tb_stat)
    );

    // prefix length of the selected entry bounds
    logic [FW-1:0] s_low;
    logic [FW-1:0] e_low;
    logic [FW-1:0] diff;
    logic [BW-1:0] cp_next;

    always_comb
    begin
        s_low = start_reg & bmask_reg;
        e_low = end_reg & bmask_reg;
        diff  = s_low ^ e_low;
        if (diff == '0)
        begin
            cp_next = beta_reg;
        end
        else
        begin
            cp_next = srs_pkg::lead_zeros(diff << (BW'(FW) - beta_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= srs_pkg::ST_IDLE;
            issued_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                srs_pkg::ST_IDLE:
                begin
                    if (acc && (mode_in == srs_pkg::MODE_ENCODE
                                || mode_in == srs_pkg::MODE_DECODE))
                    begin
                        state_reg  <= srs_pkg::ST_WALK;
                        issued_reg <= 1'b0;
                    end
                end
                srs_pkg::ST_WALK:
                begin
                    if (rd_en && walk_reg == last_reg)
                    begin
                        issued_reg <= 1'b1;
                    end
                    if (take)
                    begin
                        state_reg <= srs_pkg::ST_PREFIX;
                    end
                end
                srs_pkg::ST_PREFIX:
                begin
                    state_reg <= srs_pkg::ST_FINISH;
                end
                srs_pkg::ST_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg <= srs_pkg::ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= srs_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // item payload and walk pointer
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            dec_reg   <= (mode_in == srs_pkg::MODE_DECODE);
            beta_reg  <= beta_eff;
            bmask_reg <= bmask;
            msg_reg   <= msg_in;
            mask_reg  <= mask_in;
            r_reg     <= msg_in ^ mask_in;
            if (mode_in == srs_pkg::MODE_DECODE)
            begin
                walk_reg <= tok_idx;
                last_reg <= tok_idx;
            end
            else
            begin
                walk_reg <= '0;
                last_reg <= last_idx;
            end
        end
        else if (rd_en && walk_reg != last_reg)
        begin
            walk_reg <= walk_reg + AW'(1);
        end

        if (take)
        begin
            hit_idx_reg <= tb_idx;
            start_reg   <= tb_start;
            end_reg     <= tb_end;
        end

        if (state_reg == srs_pkg::ST_PREFIX)
        begin
            cp_reg  <= cp_next;
            sh_reg  <= beta_reg - cp_next;
            src_reg <= dec_reg ? (s_low ^ mask_reg) : msg_reg;
        end
    end

    // result register
    logic            out_valid_reg;
    logic [srs_pkg::IDX_W-1:0] out_idx_reg;
    logic [BW-1:0]   out_len_reg;
    logic [FW-1:0]   out_bits_reg;
    logic [FW-1:0]   out_masked_reg;
    logic            out_dec_reg;
    logic            out_load;

    assign out_load = (state_reg == srs_pkg::ST_FINISH) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (item_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_idx_reg    <= srs_pkg::IDX_W'(hit_idx_reg);
            out_len_reg    <= cp_reg;
            out_bits_reg   <= src_reg >> sh_reg;
            out_masked_reg <= dec_reg ? '0 : r_reg;
            out_dec_reg    <= dec_reg;
        end
    end

    assign item_out.valid        = out_valid_reg;
    assign item_out.chosen_index = out_idx_reg;
    assign item_out.prefix_len   = out_len_reg;
    assign item_out.prefix_bits  = out_bits_reg;
    assign item_out.masked_value = out_masked_reg;
    assign item_out.was_decode   = out_dec_reg;

    // checks
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == srs_pkg::ST_WALK) |-> (walk_reg <= last_reg))
        else $error("table walk pointer passed the last entry");

    a_hit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (tb_idx <= last_reg))
        else $error("selected entry lies past the last entry");

    a_step_start: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (mode_in == srs_pkg::MODE_ENCODE || mode_in == srs_pkg::MODE_DECODE))
        |=> (state_reg == srs_pkg::ST_WALK && !item_in.ready))
        else $error("encode or decode transfer did not start a table read");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (state_reg == srs_pkg::ST_IDLE && item_out.valid))
        else $error("result stage did not hand over the result");

endmodule
`default_nettype wire
